// ----- hw/rtl/tcce_pkg.sv -----
// Shared types, codes and microcode program of the text console cursor engine.
// Used by tcce_seq, tcce_dp, text_console_cursor_engine_unit and tcce_chk.
package tcce_pkg;

	localparam int OP_W   = 2;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int ADDR_W = 11;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CELL_W = ATTR_W + CHAR_W;

	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h03;

	typedef enum logic [3:0] {
		S_INIT   = 4'd0,
		S_IDLE   = 4'd1,
		S_PUT    = 4'd2,
		S_SCR_RD = 4'd3,
		S_SCR_WR = 4'd4,
		S_FILL   = 4'd5,
		S_CLR    = 4'd6,
		S_RD     = 4'd7,
		S_RESP   = 4'd8
	} step_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_DISPATCH,
		C_MORE_COPY,
		C_MORE_FILL,
		C_SCROLL,
		C_OUT_FREE
	} cond_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_PUT,
		WR_ZERO,
		WR_BLANK,
		WR_COPY
	} wr_t;

	typedef enum logic {
		RD_REQ,
		RD_COPY
	} rd_t;

	typedef enum logic [1:0] {
		CTR_HOLD,
		CTR_CLR,
		CTR_INC
	} ctr_op_t;

	typedef enum logic [1:0] {
		CUR_HOLD,
		CUR_PUT,
		CUR_HOME
	} cur_op_t;

	typedef struct packed {
		logic    take;
		cond_t   cond;
		step_t   jt;
		step_t   jf;
		wr_t     wr;
		rd_t     rd;
		ctr_op_t ctr;
		cur_op_t cur;
		logic    emit;
	} ctrl_t;

	typedef struct packed {
		logic more_copy;
		logic more_fill;
		logic scroll;
		logic out_free;
	} stat_t;

	localparam ctrl_t CW_NOP = '{
		take: 1'b0, cond: C_ALWAYS, jt: S_IDLE, jf: S_IDLE, wr: WR_NONE,
		rd: RD_REQ, ctr: CTR_HOLD, cur: CUR_HOLD, emit: 1'b0
	};

	function automatic ctrl_t microcode(input step_t s);
		ctrl_t w;
		w = CW_NOP;
		unique case (s)
			S_INIT: begin
				w.wr = WR_ZERO; w.ctr = CTR_INC;
				w.cond = C_MORE_FILL; w.jt = S_INIT; w.jf = S_IDLE;
			end
			S_IDLE: begin
				w.take = 1'b1; w.ctr = CTR_CLR;
				w.cond = C_DISPATCH; w.jf = S_IDLE;
			end
			S_PUT: begin
				w.wr = WR_PUT; w.cur = CUR_PUT;
				w.cond = C_SCROLL; w.jt = S_SCR_RD; w.jf = S_RESP;
			end
			S_SCR_RD: begin
				w.rd = RD_COPY;
				w.cond = C_ALWAYS; w.jt = S_SCR_WR;
			end
			S_SCR_WR: begin
				w.wr = WR_COPY; w.ctr = CTR_INC;
				w.cond = C_MORE_COPY; w.jt = S_SCR_RD; w.jf = S_FILL;
			end
			S_FILL: begin
				w.wr = WR_BLANK; w.ctr = CTR_INC;
				w.cond = C_MORE_FILL; w.jt = S_FILL; w.jf = S_RESP;
			end
			S_CLR: begin
				w.wr = WR_BLANK; w.ctr = CTR_INC; w.cur = CUR_HOME;
				w.cond = C_MORE_FILL; w.jt = S_CLR; w.jf = S_RESP;
			end
			S_RD: begin
				w.cond = C_ALWAYS; w.jt = S_RESP;
			end
			S_RESP: begin
				w.emit = 1'b1;
				w.cond = C_OUT_FREE; w.jt = S_IDLE; w.jf = S_RESP;
			end
			default: begin
				w.cond = C_ALWAYS; w.jt = S_IDLE;
			end
		endcase
		return w;
	endfunction

	function automatic step_t dispatch(input logic [OP_W-1:0] op);
		step_t s;
		unique case (op)
			OP_PUT:   s = S_PUT;
			OP_CLEAR: s = S_CLR;
			OP_READ:  s = S_RD;
			default:  s = S_RESP;
		endcase
		return s;
	endfunction

endpackage

// ----- hw/rtl/tcce_seq.sv -----
// Microcode sequencer: step counter, control word table and jump logic.
// Depends on tcce_pkg.
module tcce_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [tcce_pkg::OP_W-1:0] operation,
	input  tcce_pkg::stat_t           stat,
	output tcce_pkg::ctrl_t           cw
);
	import tcce_pkg::*;

	step_t step_q;
	step_t step_d;

	always_comb begin
		cw = microcode(step_q);
	end

	always_comb begin
		step_d = cw.jf;
		unique case (cw.cond)
			C_ALWAYS:    step_d = cw.jt;
			C_DISPATCH:  if (in_valid && cw.take) step_d = dispatch(operation);
			C_MORE_COPY: if (stat.more_copy) step_d = cw.jt;
			C_MORE_FILL: if (stat.more_fill) step_d = cw.jt;
			C_SCROLL:    if (stat.scroll) step_d = cw.jt;
			C_OUT_FREE:  if (stat.out_free) step_d = cw.jt;
			default:     step_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_INIT;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// ----- hw/rtl/tcce_dp.sv -----
// Datapath: cursor, sweep counter, attribute register, screen memory and result register.
// Depends on tcce_pkg; driven by the control word from tcce_seq.
module tcce_dp #(
	parameter int COLUMNS   = 80,
	parameter int TEXT_ROWS = 24,
	parameter int TAB_STOP  = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tcce_pkg::ctrl_t             cw,
	output tcce_pkg::stat_t             stat,
	input  logic                        in_valid,
	input  logic [tcce_pkg::OP_W-1:0]   operation,
	input  logic [tcce_pkg::CHAR_W-1:0] char_code,
	input  logic [tcce_pkg::ADDR_W-1:0] cell_address,
	input  logic                        cfg_we,
	input  logic [tcce_pkg::ATTR_W-1:0] cfg_wdata,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tcce_pkg::COL_W-1:0]  cursor_column,
	output logic [tcce_pkg::ROW_W-1:0]  cursor_line,
	output logic [tcce_pkg::ADDR_W-1:0] cursor_linear,
	output logic [tcce_pkg::CHAR_W-1:0] cell_character,
	output logic [tcce_pkg::ATTR_W-1:0] cell_colour
);
	import tcce_pkg::*;

	localparam int CELL_COUNT = COLUMNS * TEXT_ROWS;
	localparam int AW         = $clog2(CELL_COUNT);
	localparam int TW         = $clog2(TAB_STOP);
	localparam int IW         = (AW + 1 > ADDR_W) ? AW + 1 : ADDR_W;
	localparam int XW         = COL_W + 1;
	localparam int YW         = ROW_W + 1;
	localparam int LW         = COL_W + ROW_W;
	localparam int BS_TAB     = (COLUMNS - 1) % TAB_STOP;

	logic [OP_W-1:0]   op_q;
	logic [CHAR_W-1:0] char_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ATTR_W-1:0] attr_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [TW-1:0]     tab_q;
	logic [AW-1:0]     ctr_q;
	logic              out_valid_q;
	logic [COL_W-1:0]  col_out_q;
	logic [ROW_W-1:0]  row_out_q;
	logic [ADDR_W-1:0] lin_out_q;
	logic [CHAR_W-1:0] chr_out_q;
	logic [ATTR_W-1:0] clr_out_q;

	logic [CELL_W-1:0] mem [CELL_COUNT];
	logic [CELL_W-1:0] mem_rdata_q;

	logic              take;
	logic              load;
	logic [AW-1:0]     cur_idx;
	logic [LW-1:0]     lin;
	logic              put_we;
	logic [AW-1:0]     put_idx;
	logic [CHAR_W-1:0] put_char;
	logic [XW-1:0]     col_a;
	logic [YW-1:0]     row_a;
	logic [TW-1:0]     tab_a;
	logic              scroll;
	logic [COL_W-1:0]  col_n;
	logic [ROW_W-1:0]  row_n;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [CELL_W-1:0] wdata;
	logic [AW-1:0]     raddr;
	logic [IW-1:0]     addr_x;
	logic              rd_hit;

	assign take    = in_valid && cw.take;
	assign cur_idx = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
	assign lin     = LW'(row_q) * LW'(COLUMNS) + LW'(col_q);
	assign addr_x  = IW'(addr_q);
	assign rd_hit  = (op_q == OP_READ) && (addr_x < IW'(CELL_COUNT));

	always_comb begin
		col_a    = XW'(col_q);
		row_a    = YW'(row_q);
		tab_a    = tab_q;
		put_we   = 1'b0;
		put_idx  = cur_idx;
		put_char = char_q;
		unique case (char_q)
			CH_NL: begin
				col_a = '0;
				row_a = row_a + YW'(1);
				tab_a = '0;
			end
			CH_CR: begin
				col_a = '0;
				tab_a = '0;
			end
			CH_TAB: begin
				col_a = col_a + XW'(TAB_STOP) - XW'(tab_q);
				tab_a = '0;
			end
			CH_BS: begin
				put_idx  = cur_idx - AW'(1);
				put_char = CH_SPACE;
				if (col_q != '0) begin
					put_we = 1'b1;
					col_a  = col_a - XW'(1);
					tab_a  = (tab_q == '0) ? TW'(TAB_STOP - 1) : tab_q - TW'(1);
				end else if (row_q != '0) begin
					put_we = 1'b1;
					row_a  = row_a - YW'(1);
					col_a  = XW'(COLUMNS - 1);
					tab_a  = TW'(BS_TAB);
				end
			end
			default: begin
				put_we = 1'b1;
				col_a  = col_a + XW'(1);
				tab_a  = (tab_q == TW'(TAB_STOP - 1)) ? '0 : tab_q + TW'(1);
			end
		endcase
		if (col_a >= XW'(COLUMNS)) begin
			col_a = '0;
			row_a = row_a + YW'(1);
			tab_a = '0;
		end
		scroll = row_a >= YW'(TEXT_ROWS);
		col_n  = col_a[COL_W-1:0];
		row_n  = scroll ? ROW_W'(TEXT_ROWS - 1) : row_a[ROW_W-1:0];
	end

	always_comb begin
		we    = 1'b0;
		waddr = ctr_q;
		wdata = '0;
		unique case (cw.wr)
			WR_PUT: begin
				we    = put_we;
				waddr = put_idx;
				wdata = {attr_q, put_char};
			end
			WR_ZERO: begin
				we = 1'b1;
			end
			WR_BLANK: begin
				we    = 1'b1;
				wdata = {attr_q, CH_NUL};
			end
			WR_COPY: begin
				we    = 1'b1;
				wdata = mem_rdata_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	assign raddr = (cw.rd == RD_COPY) ? ctr_q + AW'(COLUMNS) : addr_x[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		mem_rdata_q <= mem[raddr];
	end

	assign stat.more_copy = ctr_q != AW'(CELL_COUNT - COLUMNS - 1);
	assign stat.more_fill = ctr_q != AW'(CELL_COUNT - 1);
	assign stat.scroll    = scroll;
	assign stat.out_free  = !(out_valid_q && out_stall);
	assign load           = cw.emit && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q      <= ATTR_RESET;
			col_q       <= '0;
			row_q       <= '0;
			tab_q       <= '0;
			ctr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			case (cw.cur)
				CUR_PUT: begin
					col_q <= col_n;
					row_q <= row_n;
					tab_q <= tab_a;
				end
				CUR_HOME: begin
					col_q <= '0;
					row_q <= '0;
					tab_q <= '0;
				end
				default: begin
				end
			endcase
			case (cw.ctr)
				CTR_CLR: ctr_q <= '0;
				CTR_INC: ctr_q <= ctr_q + AW'(1);
				default: begin
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q   <= operation;
			char_q <= char_code;
			addr_q <= cell_address;
		end
		if (load) begin
			col_out_q <= col_q;
			row_out_q <= row_q;
			lin_out_q <= lin[ADDR_W-1:0];
			chr_out_q <= rd_hit ? mem_rdata_q[CHAR_W-1:0] : '0;
			clr_out_q <= rd_hit ? mem_rdata_q[CELL_W-1:CHAR_W] : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign cursor_column  = col_out_q;
	assign cursor_line    = row_out_q;
	assign cursor_linear  = lin_out_q;
	assign cell_character = chr_out_q;
	assign cell_colour    = clr_out_q;

endmodule

// ----- hw/rtl/text_console_cursor_engine_unit.sv -----
// Top level of the text console cursor engine: microcode sequencer plus datapath.
// Depends on tcce_pkg, tcce_seq and tcce_dp.

// Each transaction is one console command; each yields one result with the
// cursor after the command. Put and read commands pass S_PUT or S_RD and
// load the result register in S_RESP; unused commands go straight to S_RESP.
// The next command is accepted on the cycle after the load. A stalled result
// holds the sequencer, and with it the input, until the result is taken. The
// screen store is a single memory with one write and one registered read port,
// swept by the sequencer: zeroing, clear and fill write one cell per cycle, and
// the copy reads each cell in S_SCR_RD and writes it in S_SCR_WR. Clear blanks
// every cell before it loads its result, and a put that scrolls adds a copy
// over COLUMNS*(TEXT_ROWS-1) cells plus a fill of the last row. After reset
// the store is zeroed in a pass during which no command is accepted; the
// attribute register can be written at any time the block is idle.
module text_console_cursor_engine_unit #(
	parameter int COLUMNS   = 80,
	parameter int TEXT_ROWS = 24,
	parameter int TAB_STOP  = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tcce_pkg::ATTR_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tcce_pkg::OP_W-1:0]   operation,
	input  logic [tcce_pkg::CHAR_W-1:0] char_code,
	input  logic [tcce_pkg::ADDR_W-1:0] cell_address,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tcce_pkg::COL_W-1:0]  cursor_column,
	output logic [tcce_pkg::ROW_W-1:0]  cursor_line,
	output logic [tcce_pkg::ADDR_W-1:0] cursor_linear,
	output logic [tcce_pkg::CHAR_W-1:0] cell_character,
	output logic [tcce_pkg::ATTR_W-1:0] cell_colour
);
	import tcce_pkg::*;

	ctrl_t cw;
	stat_t stat;

	assign in_stall = !cw.take;

	tcce_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.stat      (stat),
		.cw        (cw)
	);

	tcce_dp #(
		.COLUMNS   (COLUMNS),
		.TEXT_ROWS (TEXT_ROWS),
		.TAB_STOP  (TAB_STOP)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cw             (cw),
		.stat           (stat),
		.in_valid       (in_valid),
		.operation      (operation),
		.char_code      (char_code),
		.cell_address   (cell_address),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cursor_column  (cursor_column),
		.cursor_line    (cursor_line),
		.cursor_linear  (cursor_linear),
		.cell_character (cell_character),
		.cell_colour    (cell_colour)
	);

endmodule

// ----- hw/rtl/tcce_chk.sv -----
// Port-level assertions for text_console_cursor_engine_unit and the bind that attaches them.
// Depends on tcce_pkg.
module tcce_chk #(
	parameter int COLUMNS   = 80,
	parameter int TEXT_ROWS = 24
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [tcce_pkg::COL_W-1:0]  cursor_column,
	input logic [tcce_pkg::ROW_W-1:0]  cursor_line,
	input logic [tcce_pkg::ADDR_W-1:0] cursor_linear
);
	import tcce_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cursor_linear) && $stable(cursor_column))
		else $error("stalled result changed or dropped");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("command accepted on back-to-back cycles");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(cursor_column) < COLUMNS) && (int'(cursor_line) < TEXT_ROWS))
		else $error("cursor outside the screen");

	a_linear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cursor_linear ==
			ADDR_W'(int'(cursor_line) * COLUMNS + int'(cursor_column)))
		else $error("linear cursor does not match column and row");

endmodule

bind text_console_cursor_engine_unit tcce_chk #(
	.COLUMNS   (COLUMNS),
	.TEXT_ROWS (TEXT_ROWS)
) u_tcce_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.cursor_column (cursor_column),
	.cursor_line   (cursor_line),
	.cursor_linear (cursor_linear)
);
